// ===== src/afr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// shared types, codes and header/crc helpers for the record framer
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned HDR_IDX_W  = 5;

  // action codes of an input item
  localparam logic [ACT_W-1:0] ACT_NAME    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PAYLOAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_END     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNCOMPRESSED_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CRC          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD_CODE       = 2'd3;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 5'd25;
  localparam logic [CRC_W-1:0]     CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]     CRC_POLY   = 16'h1021;
  localparam logic [BYTE_W-1:0]    HDR_MAGIC  = 8'h52;
  localparam logic [BYTE_W-1:0]    HDR_VER    = 8'h01;
  localparam logic [15:0]          METHOD_RST = 16'h0001;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NAME,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    SEG_HDR,
    SEG_TERM,
    SEG_BODY
  } seg_t;

  typedef enum logic [1:0] {
    K_NAME,
    K_PAYLOAD,
    K_END
  } kind_t;

  // one classified item as handed from front to back
  typedef struct packed {
    logic              hdr;
    logic              term;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  crc;
  } cmd_t;

  typedef struct packed {
    logic [31:0] compressed_size;
    logic [31:0] uncompressed_size;
    logic [15:0] data_crc;
    logic [15:0] method_code;
  } cfg_regs_t;

  typedef struct packed {
    phase_t           phase;
    logic [CRC_W-1:0] crc;
  } front_stat_t;

  // crc16-ccitt, msb first, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[CRC_W-1]) r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      else            r = {r[CRC_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // header byte at a given offset
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                                 input cfg_regs_t regs);
    logic [BYTE_W-1:0] v;
    case (idx)
      5'd0, 5'd1:   v = HDR_MAGIC;
      5'd2:         v = HDR_VER;
      5'd8:         v = regs.compressed_size[7:0];
      5'd9:         v = regs.compressed_size[15:8];
      5'd10:        v = regs.compressed_size[23:16];
      5'd11:        v = regs.compressed_size[31:24];
      5'd12:        v = regs.uncompressed_size[7:0];
      5'd13:        v = regs.uncompressed_size[15:8];
      5'd14:        v = regs.uncompressed_size[23:16];
      5'd15:        v = regs.uncompressed_size[31:24];
      5'd16, 5'd17: v = 8'hFF;
      5'd18:        v = regs.data_crc[7:0];
      5'd19:        v = regs.data_crc[15:8];
      5'd22:        v = 8'h01;
      5'd24:        v = regs.method_code[7:0];
      5'd25:        v = regs.method_code[15:8];
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/afr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_in_if
// input item channel: action and data byte
// ----------------------------------------------------------------------------
interface afr_in_if;
  import afr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== src/afr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_out_if
// framed byte stream channel
// ----------------------------------------------------------------------------
interface afr_out_if;
  import afr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              record_end;

  modport source (output valid, output out_byte, output run_last, output record_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input record_end,
                  output ready);
endinterface
`default_nettype wire

// ===== src/afr_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface afr_cfg_if;
  import afr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/afr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_front
// accepts items, tracks the record phase and payload crc, issues commands
// ----------------------------------------------------------------------------
module afr_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  afr_in_if.sink                    rec_in,
  output afr_pkg::cmd_t             cmd,
  output logic                      cmd_valid,
  input  wire logic                 cmd_full,
  output afr_pkg::front_stat_t      stat
);
  import afr_pkg::*;

  phase_t           phase, phase_next;
  logic [CRC_W-1:0] crc, crc_next;
  logic             accept;
  logic             drop;

  assign rec_in.ready = !cmd_full;
  assign accept       = rec_in.valid && rec_in.ready;

  // unknown action, or name byte once payload has started
  assign drop = (rec_in.action != ACT_NAME && rec_in.action != ACT_PAYLOAD &&
                 rec_in.action != ACT_END) ||
                (rec_in.action == ACT_NAME && phase == PH_PAYLOAD);

  // command build
  always_comb begin
    cmd_valid = accept && !drop;
    cmd.hdr   = (phase == PH_IDLE);
    cmd.term  = (rec_in.action != ACT_NAME) && (phase != PH_PAYLOAD);
    cmd.data  = rec_in.data_byte;
    cmd.crc   = crc;
    cmd.kind  = K_NAME;
    if (rec_in.action == ACT_PAYLOAD) cmd.kind = K_PAYLOAD;
    if (rec_in.action == ACT_END)     cmd.kind = K_END;
  end

  // next phase and crc
  always_comb begin
    phase_next = phase;
    crc_next   = crc;
    if (cmd_valid) begin
      case (rec_in.action)
        ACT_NAME: begin
          phase_next = PH_NAME;
        end
        ACT_PAYLOAD: begin
          phase_next = PH_PAYLOAD;
          crc_next   = crc_byte(crc, rec_in.data_byte);
        end
        ACT_END: begin
          phase_next = PH_IDLE;
          crc_next   = CRC_INIT;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      crc   <= CRC_INIT;
    end else begin
      phase <= phase_next;
      crc   <= crc_next;
    end
  end

  assign stat.phase = phase;
  assign stat.crc   = crc;

endmodule
`default_nettype wire

// ===== src/afr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module afr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  afr_pkg::cmd_t       push_data,
  output logic                full,
  input  wire logic           pop,
  output afr_pkg::cmd_t       head,
  output logic                head_valid
);
  import afr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/afr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_back
// expands one command into header, terminator and body bytes
// ----------------------------------------------------------------------------
module afr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  afr_pkg::cmd_t       head,
  input  wire logic           head_valid,
  output logic                pop,
  input  afr_pkg::cfg_regs_t  regs,
  afr_out_if.source           rec_out
);
  import afr_pkg::*;

  seg_t                 seg, seg_next, eff_seg, after_seg;
  logic                 busy, busy_next;
  logic [HDR_IDX_W-1:0] idx, idx_next, eff_idx;
  logic                 load;
  logic                 seg_last, cmd_last;
  logic [BYTE_W-1:0]    byte_val;

  logic                 ov;
  logic [BYTE_W-1:0]    ob;
  logic                 ol, oe;

  // a fresh command starts in its first segment
  always_comb begin
    if (busy) begin
      eff_seg = seg;
      eff_idx = idx;
    end else begin
      eff_idx = '0;
      if (head.hdr)       eff_seg = SEG_HDR;
      else if (head.term) eff_seg = SEG_TERM;
      else                eff_seg = SEG_BODY;
    end
  end

  assign load = head_valid && (!ov || rec_out.ready);

  // outputs of the sequencer
  always_comb begin
    byte_val  = '0;
    seg_last  = 1'b1;
    after_seg = SEG_BODY;
    unique case (eff_seg)
      SEG_HDR: begin
        byte_val  = hdr_byte(eff_idx, regs);
        seg_last  = (eff_idx == HDR_LAST);
        after_seg = head.term ? SEG_TERM : SEG_BODY;
      end
      SEG_TERM: begin
        byte_val = '0;
      end
      SEG_BODY: begin
        if (head.kind == K_END) begin
          byte_val = eff_idx[0] ? head.crc[15:8] : head.crc[7:0];
          seg_last = eff_idx[0];
        end else begin
          byte_val = head.data;
        end
      end
      default: begin
        byte_val = '0;
      end
    endcase
    cmd_last = (eff_seg == SEG_BODY) && seg_last;
    pop      = load && cmd_last;
  end

  // next state
  always_comb begin
    busy_next = busy;
    seg_next  = seg;
    idx_next  = idx;
    if (load) begin
      if (cmd_last) begin
        busy_next = 1'b0;
        seg_next  = SEG_HDR;
        idx_next  = '0;
      end else if (seg_last) begin
        busy_next = 1'b1;
        seg_next  = after_seg;
        idx_next  = '0;
      end else begin
        busy_next = 1'b1;
        seg_next  = eff_seg;
        idx_next  = eff_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seg  <= SEG_HDR;
      idx  <= '0;
      ov   <= 1'b0;
    end else begin
      busy <= busy_next;
      seg  <= seg_next;
      idx  <= idx_next;
      if (load)               ov <= 1'b1;
      else if (rec_out.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob <= byte_val;
      ol <= cmd_last;
      oe <= cmd_last && (head.kind == K_END);
    end
  end

  assign rec_out.valid      = ov;
  assign rec_out.out_byte   = ob;
  assign rec_out.run_last   = ol;
  assign rec_out.record_end = oe;

endmodule
`default_nettype wire

// ===== src/archive_record_framer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// archive_record_framer_unit
// frames one archive record (header, name, zero, payload, crc trailer)
// ----------------------------------------------------------------------------
// Each name or payload item goes through the command queue and gives one
// output byte via the back end's output register; bytes leave one per cycle
// while rec_out is ready, and a record adds 26 header bytes, one name
// terminator byte and two crc trailer bytes. The front accepts items
// whenever the command queue (QUEUE_DEPTH entries) has room, so during the
// header burst the queue holds the item being expanded and takes up to
// QUEUE_DEPTH - 1 more; then the back end's header sequencer sets the pace.
// Registers are written through cfg, which is always ready; they are read
// while the header is sent, so write them only between records.
module archive_record_framer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  afr_in_if.sink    rec_in,
  afr_out_if.source rec_out,
  afr_cfg_if.sink   cfg
);
  import afr_pkg::*;

  cfg_regs_t   regs;
  cmd_t        cmd, head;
  logic        cmd_valid, cmd_full;
  logic        head_valid, pop;
  front_stat_t stat;

  // register file, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.compressed_size   <= '0;
      regs.uncompressed_size <= '0;
      regs.data_crc          <= '0;
      regs.method_code       <= METHOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COMPRESSED_SIZE:   regs.compressed_size   <= cfg.data;
        REG_UNCOMPRESSED_SIZE: regs.uncompressed_size <= cfg.data;
        REG_DATA_CRC:          regs.data_crc          <= cfg.data[15:0];
        REG_METHOD_CODE:       regs.method_code       <= cfg.data[15:0];
        default:               regs                   <= regs;
      endcase
    end
  end

  // front: classify each item, run the payload crc
  afr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rec_in    (rec_in),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_full  (cmd_full),
    .stat      (stat)
  );

  // command queue decouples intake from the byte sequencer
  afr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_data  (cmd),
    .full       (cmd_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back: header, terminator and body bytes through an output register
  afr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .regs       (regs),
    .rec_out    (rec_out)
  );

  // the final trailer byte always closes its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (rec_out.valid && rec_out.record_end) |-> rec_out.run_last)
    else $error("record end without run last");

  // between records the payload crc sits at its initial value
  a_idle_crc: assert property (@(posedge clk) disable iff (rst)
    (stat.phase == PH_IDLE) |-> (stat.crc == CRC_INIT))
    else $error("crc not reset while idle");

  // an accepted end mark returns the front to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (rec_in.valid && rec_in.ready && rec_in.action == ACT_END)
    |=> (stat.phase == PH_IDLE))
    else $error("front not idle after end of record");

endmodule
`default_nettype wire
